// ===== hdl/rgdt_pkg.sv =====
// Package for the RGB565 gray downscale tiler.
// Holds the frame geometry, the derived widths and the position struct.
// No dependencies.
package rgdt_pkg;

  localparam int SRC_WIDTH  = 320;
  localparam int SRC_HEIGHT = 240;
  localparam int TEX_WIDTH  = 256;

  localparam int LINE_DEPTH    = SRC_WIDTH / 2;
  localparam int OUT_HEIGHT    = SRC_HEIGHT / 2;
  localparam int TILES_PER_ROW = TEX_WIDTH / 8;

  localparam int COL_W    = 9;
  localparam int ROW_W    = 8;
  localparam int SLOT_W   = COL_W - 1;
  localparam int HROW_W   = ROW_W - 1;
  localparam int LINE_AW  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int GRAY_W   = 8;
  localparam int PAIR_W   = GRAY_W + 1;
  localparam int IDX_W    = 15;
  localparam int PIX_W    = 16;

  typedef struct packed {
    logic              col_odd;
    logic              row_odd;
    logic              slot_ok;
    logic              row_ok;
    logic [SLOT_W-1:0] slot;
    logic [HROW_W-1:0] half_row;
  } pos_t;

endpackage

// ===== hdl/rgdt_pos_count.sv =====
// Column and row counters of the incoming raster.
// Gives the position of the item being accepted; uses rgdt_pkg.
module rgdt_pos_count (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          frame_start,
  output rgdt_pkg::pos_t pos
);
  import rgdt_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;

  assign col_cur = frame_start ? '0 : col_r;
  assign row_cur = frame_start ? '0 : row_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_cur >= COL_W'(SRC_WIDTH - 1)) begin
        col_nxt = '0;
        row_nxt = (row_cur >= ROW_W'(SRC_HEIGHT - 1)) ? '0 : row_cur + 1'b1;
      end else begin
        col_nxt = col_cur + 1'b1;
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    pos.col_odd  = col_cur[0];
    pos.row_odd  = row_cur[0];
    pos.slot     = col_cur[COL_W-1:1];
    pos.half_row = row_cur[ROW_W-1:1];
    pos.slot_ok  = ({1'b0, col_cur[COL_W-1:1]} < COL_W'(LINE_DEPTH));
    pos.row_ok   = ({1'b0, row_cur[ROW_W-1:1]} < ROW_W'(OUT_HEIGHT));
  end

endmodule

// ===== hdl/rgdt_luma.sv =====
// Luma of one RGB565 pixel with weights 77/150/29.
// Channels are widened to 8 bits by bit replication; uses rgdt_pkg.
module rgdt_luma (
  input  logic [rgdt_pkg::PIX_W-1:0]  pixel,
  output logic [rgdt_pkg::GRAY_W-1:0] gray
);
  import rgdt_pkg::*;

  logic [7:0]  r8, g8, b8;
  logic [15:0] sum;

  assign r8 = {pixel[15:11], pixel[15:13]};
  assign g8 = {pixel[10:5], pixel[10:9]};
  assign b8 = {pixel[4:0], pixel[4:2]};

  assign sum = 16'(16'(r8) * 16'd77) + 16'(16'(g8) * 16'd150) + 16'(16'(b8) * 16'd29);
  assign gray = sum[15:8];

endmodule

// ===== hdl/rgdt_tex_addr.sv =====
// Texture index of one output block: vertical flip, 8x8 tiles, Morton order inside.
// Uses rgdt_pkg.
module rgdt_tex_addr (
  input  logic [rgdt_pkg::SLOT_W-1:0] slot,
  input  logic [rgdt_pkg::HROW_W-1:0] half_row,
  output logic [rgdt_pkg::IDX_W-1:0]  tex_index
);
  import rgdt_pkg::*;

  logic [HROW_W-1:0] y;
  logic [5:0]        morton;
  logic [IDX_W-1:0]  tile;

  assign y = HROW_W'(OUT_HEIGHT - 1) - half_row;
  assign morton = {y[2], slot[2], y[1], slot[1], y[0], slot[0]};
  assign tile = IDX_W'(IDX_W'(y >> 3) * IDX_W'(TILES_PER_ROW)) + IDX_W'(slot >> 3);
  assign tex_index = IDX_W'({tile, morton});

endmodule

// ===== hdl/rgdt_block_avg.sv =====
// Line store of horizontal pair sums and the 2x2 average of each block.
// Holds the left gray of the current pair; uses rgdt_pkg.
module rgdt_block_avg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [rgdt_pkg::SLOT_W-1:0] rd_slot,
  input  logic                        commit,
  input  rgdt_pkg::pos_t              pos,
  input  logic [rgdt_pkg::GRAY_W-1:0] gray,
  output logic                        emit,
  output logic [rgdt_pkg::PIX_W-1:0]  tex_pixel
);
  import rgdt_pkg::*;

  logic [PAIR_W-1:0] line_mem [LINE_DEPTH];
  logic [PAIR_W-1:0] rd_data_r;
  logic [GRAY_W-1:0] left_gray_r;
  logic [PAIR_W-1:0] pair;
  logic [PAIR_W:0]   quad;
  logic [GRAY_W-1:0] avg;
  logic              wr_en;

  assign pair  = PAIR_W'(left_gray_r) + PAIR_W'(gray);
  assign quad  = (PAIR_W + 1)'(rd_data_r) + (PAIR_W + 1)'(pair);
  assign avg   = quad[PAIR_W:2];
  assign emit  = pos.col_odd && pos.slot_ok && pos.row_odd && pos.row_ok;
  assign wr_en = commit && pos.col_odd && pos.slot_ok && !pos.row_odd;
  assign tex_pixel = {avg[7:3], avg[7:2], avg[7:3]};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= line_mem[rd_slot[LINE_AW-1:0]];
    end
    if (wr_en) begin
      line_mem[pos.slot[LINE_AW-1:0]] <= pair;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_gray_r <= '0;
    end else if (commit && !pos.col_odd) begin
      left_gray_r <= gray;
    end
  end

endmodule

// ===== hdl/rgb565_gray_downscale_tiler.sv =====
// Top level of the RGB565 gray downscale tiler.
// Instantiates rgdt_pos_count, rgdt_luma, rgdt_tex_addr and rgdt_block_avg; uses rgdt_pkg.
//
// The block takes one camera pixel per clock and can keep that rate without
// end when the output side is ready. Each item passes an input register, a
// luma register and a result register, in that order; a stall on the output
// holds the pipeline, and ready on the input follows it in the same cycle.
// One result comes out for every 2x2 block, on the pixel of the odd row and
// odd column. The first pixel after reset and every pixel flagged as a frame
// start is column 0, row 0. The line store needs no clearing after reset.
module rgb565_gray_downscale_tiler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] pixel_rgb565
  input  logic [0:0]  in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [14:0] tex_index, [30:15] tex_pixel, [31] zero
);
  import rgdt_pkg::*;

  logic              accept;
  pos_t              in_pos;
  logic              s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0]  s1_px_r;
  pos_t              s1_pos_r;
  logic [GRAY_W-1:0] s1_gray;
  logic [IDX_W-1:0]  s1_idx;
  logic              s2_valid_r, s2_valid_nxt;
  logic [GRAY_W-1:0] s2_gray_r;
  logic [IDX_W-1:0]  s2_idx_r;
  pos_t              s2_pos_r;
  logic              emit;
  logic [PIX_W-1:0]  blk_pixel;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_free, adv1, adv2, s2_ready;

  assign out_free  = !out_valid_r || out_tready;
  assign adv2      = s2_valid_r && out_free;
  assign s2_ready  = !s2_valid_r || adv2;
  assign adv1      = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || adv1;
  assign accept    = in_tvalid && in_tready;

  rgdt_pos_count u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .frame_start (in_tuser[0]),
    .pos         (in_pos)
  );

  rgdt_luma u_luma (
    .pixel (s1_px_r),
    .gray  (s1_gray)
  );

  rgdt_tex_addr u_addr (
    .slot      (s1_pos_r.slot),
    .half_row  (s1_pos_r.half_row),
    .tex_index (s1_idx)
  );

  rgdt_block_avg u_avg (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (adv1 && s1_pos_r.col_odd && s1_pos_r.slot_ok),
    .rd_slot   (s1_pos_r.slot),
    .commit    (adv2),
    .pos       (s2_pos_r),
    .gray      (s2_gray_r),
    .emit      (emit),
    .tex_pixel (blk_pixel)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (adv1) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_valid_r;
    if (adv1) begin
      s2_valid_nxt = 1'b1;
    end else if (adv2) begin
      s2_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv2 && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r  <= in_tdata;
      s1_pos_r <= in_pos;
    end
    if (adv1) begin
      s2_gray_r <= s1_gray;
      s2_idx_r  <= s1_idx;
      s2_pos_r  <= s1_pos_r;
    end
    if (adv2 && emit) begin
      out_idx_r <= s2_idx_r;
      out_pix_r <= blk_pixel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pix_r, out_idx_r};

endmodule
